@@ rtl/core/fti_pkg.sv @@
// shared types and constants for the flow temperature curve interpolator
`timescale 1ns / 1ps

package fti_pkg;

	// table size and derived widths
	localparam int MaxPoints = 16;
	localparam int IdxW      = $clog2(MaxPoints);
	localparam int CntW      = $clog2(MaxPoints + 1);

	// field widths
	localparam int FlowW   = 16;
	localparam int TempW   = 14;
	localparam int EntryW  = FlowW + TempW;
	localparam int ProdW   = TempW + FlowW;
	localparam int CfgIdxW = 8;
	localparam int CfgDatW = 14;

	localparam logic [TempW-1:0] DefaultTempRst = TempW'(3200);
	localparam logic [TempW-1:0] TempMax        = {TempW{1'b1}};

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgCurveEnable = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CfgDefaultTemp = CfgIdxW'(1);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OUT_DEFAULT  = 3'd0,
		OUT_FIRST    = 3'd1,
		OUT_INTERP   = 3'd2,
		OUT_LAST     = 3'd3,
		OUT_CLEARED  = 3'd4,
		OUT_APPENDED = 3'd5,
		OUT_FULL     = 3'd6
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_WALK,
		ST_MUL,
		ST_DIV_START,
		ST_DIV_WAIT
	} state_t;

	// divider status toward the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/core/fti_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps

interface fti_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic [fti_pkg::FlowW-1:0]  flow;
	logic [fti_pkg::TempW-1:0]  point_temp;

	modport source (output valid, output action, output flow, output point_temp, input ready);
	modport sink (input valid, input action, input flow, input point_temp, output ready);
endinterface

interface fti_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [fti_pkg::TempW-1:0]  temperature;
	logic [2:0]                 outcome;

	modport source (output valid, output temperature, output outcome, input ready);
	modport sink (input valid, input temperature, input outcome, output ready);
endinterface

@@ rtl/core/fti_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fti_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fti_pkg::ProdW-1:0]  dividend,
	input  logic [fti_pkg::FlowW-1:0]  divisor,
	output logic [fti_pkg::ProdW-1:0]  quotient,
	output fti_pkg::div_stat_t         stat
);

	localparam int StepW = $clog2(fti_pkg::ProdW + 1);

	logic [fti_pkg::ProdW-1:0] quo_q;
	logic [fti_pkg::FlowW-1:0] rem_q;
	logic [fti_pkg::FlowW-1:0] dvs_q;
	logic [StepW-1:0]          step_q;
	logic                      busy_q;
	logic                      done_q;
	logic [fti_pkg::FlowW:0]   trial;
	logic                      fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[fti_pkg::ProdW-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(fti_pkg::ProdW);
			end else if (busy_q) begin
				step_q <= step_q - StepW'(1);
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[fti_pkg::ProdW-2:0], fits};
			rem_q <= fits ? fti_pkg::FlowW'(trial - {1'b0, dvs_q})
			              : trial[fti_pkg::FlowW-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/core/flow_temp_curve_interp.sv @@
// flow to temperature curve: point table in memory, walk and serial interpolation
// clear and append results pass the pending register, then the output register
// query: a default answer takes the same path; otherwise the first point is read,
// then one more read per table entry walked; interpolation adds the multiply, the
// divider start, 30 divider steps and done; one request at a time
// reset: curve disabled, default temp 3200, table empty, point entries undefined
`timescale 1ns / 1ps

module flow_temp_curve_interp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fti_pkg::CfgIdxW-1:0]   cfg_idx,
	input  logic [fti_pkg::CfgDatW-1:0]   cfg_data,
	fti_req_if.sink                       req,
	fti_rsp_if.source                     rsp
);

	localparam int FW = fti_pkg::FlowW;
	localparam int TW = fti_pkg::TempW;

	// configuration
	logic          enable_q;
	logic [TW-1:0] default_temp_q;

	// point table
	logic [fti_pkg::EntryW-1:0] mem [fti_pkg::MaxPoints];
	logic [fti_pkg::EntryW-1:0] rd_q;
	logic [fti_pkg::CntW-1:0]   count_q;

	// query working registers
	fti_pkg::state_t          state_q, state_d;
	logic [FW-1:0]            q_q;
	logic [FW-1:0]            f0_q;
	logic [TW-1:0]            t0_q;
	logic [fti_pkg::IdxW-1:0] idx_q;
	logic                     neg_q;
	logic [TW-1:0]            dt_mag_q;
	logic [FW-1:0]            dq_q;
	logic [FW-1:0]            span_q;
	logic [fti_pkg::ProdW-1:0] prod_q;

	// result buffering
	logic          pend_valid_q;
	logic [TW-1:0] pend_temp_q;
	logic [2:0]    pend_outcome_q;
	logic          out_valid_q;
	logic [TW-1:0] out_temp_q;
	logic [2:0]    out_outcome_q;

	logic                      accept;
	logic                      move;
	logic                      rd_en;
	logic [fti_pkg::IdxW-1:0]  rd_addr;
	logic                      wr_en;
	logic                      res_load;
	logic [TW-1:0]             res_temp;
	fti_pkg::outcome_t         res_outcome;
	logic                      div_start;
	logic [fti_pkg::ProdW-1:0] div_quo;
	fti_pkg::div_stat_t        div_stat;
	logic [FW-1:0]             rd_flow;
	logic [TW-1:0]             rd_temp;
	logic                      at_last;
	logic signed [TW+2:0]      interp_sum;
	logic [TW-1:0]             interp_temp;

	assign rd_flow = rd_q[fti_pkg::EntryW-1:TW];
	assign rd_temp = rd_q[TW-1:0];
	assign accept  = req.valid && req.ready;
	assign req.ready = (state_q == fti_pkg::ST_IDLE) && !pend_valid_q;
	assign move    = pend_valid_q && (!out_valid_q || rsp.ready);
	assign wr_en   = accept && (fti_pkg::action_t'(req.action) == fti_pkg::ACT_APPEND)
	                 && (count_q < fti_pkg::CntW'(fti_pkg::MaxPoints));
	assign at_last = (fti_pkg::CntW'(idx_q) + fti_pkg::CntW'(1)) == count_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			default_temp_q <= fti_pkg::DefaultTempRst;
		end else if (cfg_we) begin
			case (cfg_idx)
				fti_pkg::CfgCurveEnable: enable_q <= cfg_data[0];
				fti_pkg::CfgDefaultTemp: default_temp_q <= cfg_data[TW-1:0];
				default: ;
			endcase
		end
	end

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[fti_pkg::IdxW-1:0]] <= {req.flow, req.point_temp};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && fti_pkg::action_t'(req.action) == fti_pkg::ACT_CLEAR) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + fti_pkg::CntW'(1);
		end
	end

	// interpolated temperature with saturation
	always_comb begin
		if (neg_q) begin
			interp_sum = $signed({3'b000, t0_q}) - $signed({3'b000, div_quo[TW-1:0]});
		end else begin
			interp_sum = $signed({3'b000, t0_q}) + $signed({3'b000, div_quo[TW-1:0]});
		end
		if (interp_sum < 0) begin
			interp_temp = '0;
		end else if (interp_sum > $signed({3'b000, fti_pkg::TempMax})) begin
			interp_temp = fti_pkg::TempMax;
		end else begin
			interp_temp = interp_sum[TW-1:0];
		end
	end

	// sequencer: next state, table reads and results
	always_comb begin
		state_d     = state_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		res_load    = 1'b0;
		res_temp    = '0;
		res_outcome = fti_pkg::OUT_DEFAULT;
		div_start   = 1'b0;
		case (state_q)
			fti_pkg::ST_IDLE: begin
				if (accept) begin
					case (fti_pkg::action_t'(req.action))
						fti_pkg::ACT_CLEAR: begin
							res_load    = 1'b1;
							res_outcome = fti_pkg::OUT_CLEARED;
						end
						fti_pkg::ACT_APPEND: begin
							res_load    = 1'b1;
							res_outcome = wr_en ? fti_pkg::OUT_APPENDED : fti_pkg::OUT_FULL;
						end
						fti_pkg::ACT_QUERY: begin
							if (!enable_q || count_q == '0) begin
								res_load    = 1'b1;
								res_temp    = default_temp_q;
								res_outcome = fti_pkg::OUT_DEFAULT;
							end else begin
								rd_en   = 1'b1;
								state_d = fti_pkg::ST_FIRST;
							end
						end
						default: ;
					endcase
				end
			end
			fti_pkg::ST_FIRST: begin
				if (count_q == fti_pkg::CntW'(1) || q_q < rd_flow) begin
					res_load    = 1'b1;
					res_temp    = rd_temp;
					res_outcome = fti_pkg::OUT_FIRST;
					state_d     = fti_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = fti_pkg::IdxW'(1);
					state_d = fti_pkg::ST_WALK;
				end
			end
			fti_pkg::ST_WALK: begin
				if (rd_flow >= q_q) begin
					if (rd_flow == f0_q) begin
						res_load    = 1'b1;
						res_temp    = t0_q;
						res_outcome = fti_pkg::OUT_INTERP;
						state_d     = fti_pkg::ST_IDLE;
					end else begin
						state_d = fti_pkg::ST_MUL;
					end
				end else if (at_last) begin
					res_load    = 1'b1;
					res_temp    = rd_temp;
					res_outcome = fti_pkg::OUT_LAST;
					state_d     = fti_pkg::ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + fti_pkg::IdxW'(1);
				end
			end
			fti_pkg::ST_MUL: begin
				state_d = fti_pkg::ST_DIV_START;
			end
			fti_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = fti_pkg::ST_DIV_WAIT;
			end
			fti_pkg::ST_DIV_WAIT: begin
				if (div_stat.done) begin
					res_load    = 1'b1;
					res_temp    = interp_temp;
					res_outcome = fti_pkg::OUT_INTERP;
					state_d     = fti_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fti_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// query datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fti_pkg::ST_IDLE: begin
				if (accept) begin
					q_q <= req.flow;
				end
			end
			fti_pkg::ST_FIRST: begin
				f0_q  <= rd_flow;
				t0_q  <= rd_temp;
				idx_q <= fti_pkg::IdxW'(1);
			end
			fti_pkg::ST_WALK: begin
				if (rd_flow >= q_q) begin
					neg_q    <= rd_temp < t0_q;
					dt_mag_q <= (rd_temp < t0_q) ? t0_q - rd_temp : rd_temp - t0_q;
					dq_q     <= q_q - f0_q;
					span_q   <= rd_flow - f0_q;
				end else begin
					f0_q  <= rd_flow;
					t0_q  <= rd_temp;
					idx_q <= idx_q + fti_pkg::IdxW'(1);
				end
			end
			fti_pkg::ST_MUL: begin
				prod_q <= {{(fti_pkg::ProdW-TW){1'b0}}, dt_mag_q}
				          * {{(fti_pkg::ProdW-FW){1'b0}}, dq_q};
			end
			default: ;
		endcase
	end

	fti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (span_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			pend_temp_q    <= res_temp;
			pend_outcome_q <= res_outcome;
		end
		if (move) begin
			out_temp_q    <= pend_temp_q;
			out_outcome_q <= pend_outcome_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.temperature = out_temp_q;
	assign rsp.outcome     = out_outcome_q;

endmodule
